[rtl/cvvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvvt_pkg: shared types and constants of the token scanner
// Request/result payloads, event records and the scan mode encoding.
// ----------------------------------------------------------------------------
package cvvt_pkg;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_CONST   = 2'd1,
    KIND_VALUE   = 2'd2,
    KIND_VECTOR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EV_START      = 3'd0,
    EV_DATA       = 3'd1,
    EV_ELEM_START = 3'd2,
    EV_ELEM_END   = 3'd3,
    EV_END        = 3'd4
  } event_e;

  typedef enum logic [4:0] {
    MODE_TOP    = 5'b00001,
    MODE_CONST  = 5'b00010,
    MODE_VALUE  = 5'b00100,
    MODE_VECTOR = 5'b01000,
    MODE_ELEM   = 5'b10000
  } mode_e;

  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_LBRACK     = 8'h5B;
  localparam logic [7:0] CH_RBRACK     = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DASH       = 8'h2D;

  // at most four events follow from one request
  localparam int MaxEvents = 4;
  localparam int EvIdxW    = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_req_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic       last_of_run;
  } out_res_t;

  typedef struct packed {
    kind_e      kind;
    event_e     ev;
    logic [7:0] data;
  } evt_t;

  // events of one request, valid from index 0 up to last_idx
  typedef struct packed {
    logic [EvIdxW-1:0]          last_idx;
    evt_t [MaxEvents-1:0]       evts;
  } batch_t;

endpackage

[rtl/cvvt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvvt_front: request classifier
// Holds the scan mode and turns each accepted byte into a batch of events.
// ----------------------------------------------------------------------------
module cvvt_front import cvvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  input  in_req_t req_i,
  input  logic    q_full_i,
  output logic    req_ready_o,
  output logic    batch_valid_o,
  output batch_t  batch_o
);

  mode_e mode_q, mode_d;

  function automatic evt_t mk_evt(kind_e k, event_e e, logic [7:0] d);
    evt_t r;
    r.kind = k;
    r.ev   = e;
    r.data = (e == EV_DATA) ? d : 8'h00;
    return r;
  endfunction

  function automatic logic is_white(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_const_char(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b == CH_UNDERSCORE) || (b == CH_DASH);
  endfunction

  logic                 accept;
  logic [7:0]           b;
  logic                 to_top;
  logic [2:0]           n;
  evt_t [MaxEvents-1:0] evts;

  assign req_ready_o = !q_full_i;
  assign accept      = req_valid_i && !q_full_i;
  assign b           = req_i.in_byte;

  always_comb begin
    mode_d = mode_q;
    to_top = 1'b0;
    n      = 3'd0;
    evts   = '0;

    unique case (mode_q)
      MODE_CONST: begin
        if (is_const_char(b)) begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_CONST, EV_DATA, b);
          n = n + 3'd1;
        end else begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_CONST, EV_END, b);
          n = n + 3'd1;
          to_top = 1'b1;
        end
      end
      MODE_VALUE: begin
        if (b == CH_QUOTE) begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VALUE, EV_END, b);
          n = n + 3'd1;
          mode_d = MODE_TOP;
        end else begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VALUE, EV_DATA, b);
          n = n + 3'd1;
        end
      end
      MODE_VECTOR: begin
        if (b == CH_RBRACK) begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_END, b);
          n = n + 3'd1;
          mode_d = MODE_TOP;
        end else if (b == CH_QUOTE) begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_ELEM_START, b);
          n = n + 3'd1;
          mode_d = MODE_ELEM;
        end
      end
      MODE_ELEM: begin
        if (b == CH_QUOTE) begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_ELEM_END, b);
          n = n + 3'd1;
          mode_d = MODE_VECTOR;
        end else begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_DATA, b);
          n = n + 3'd1;
        end
      end
      default: begin
        to_top = 1'b1;
      end
    endcase

    // top-level handling, also for the byte that ended a const
    if (to_top) begin
      mode_d = MODE_TOP;
      if (is_white(b) || b == CH_UNDERSCORE || b == CH_DASH) begin
        mode_d = MODE_TOP;
      end else if (b == CH_DOLLAR) begin
        evts[n[EvIdxW-1:0]] = mk_evt(KIND_CONST, EV_START, b);
        n = n + 3'd1;
        mode_d = MODE_CONST;
      end else if (b == CH_QUOTE) begin
        evts[n[EvIdxW-1:0]] = mk_evt(KIND_VALUE, EV_START, b);
        n = n + 3'd1;
        mode_d = MODE_VALUE;
      end else if (b == CH_LBRACK) begin
        evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_START, b);
        n = n + 3'd1;
        mode_d = MODE_VECTOR;
      end else begin
        evts[n[EvIdxW-1:0]] = mk_evt(KIND_UNKNOWN, EV_START, b);
        n = n + 3'd1;
        evts[n[EvIdxW-1:0]] = mk_evt(KIND_UNKNOWN, EV_DATA, b);
        n = n + 3'd1;
        evts[n[EvIdxW-1:0]] = mk_evt(KIND_UNKNOWN, EV_END, b);
        n = n + 3'd1;
      end
    end

    // end of text closes whatever is still open
    if (req_i.is_last) begin
      unique case (mode_d)
        MODE_CONST: begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_CONST, EV_END, b);
          n = n + 3'd1;
        end
        MODE_VALUE: begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VALUE, EV_END, b);
          n = n + 3'd1;
        end
        MODE_ELEM: begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_ELEM_END, b);
          n = n + 3'd1;
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_END, b);
          n = n + 3'd1;
        end
        MODE_VECTOR: begin
          evts[n[EvIdxW-1:0]] = mk_evt(KIND_VECTOR, EV_END, b);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      mode_d = MODE_TOP;
    end
  end

  assign batch_valid_o    = accept && (n != 3'd0);
  assign batch_o.evts     = evts;
  assign batch_o.last_idx = EvIdxW'(n - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TOP;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

[rtl/cvvt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvvt_queue: event batch queue
// Small register FIFO between the classifier and the event sequencer.
// ----------------------------------------------------------------------------
module cvvt_queue import cvvt_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  batch_t wr_data_i,
  output logic   full_o,
  input  logic   rd_en_i,
  output batch_t rd_data_o,
  output logic   valid_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  batch_t            mem_q [Depth];
  logic [IdxW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [IdxW-1:0] next_ptr(logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + IdxW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (rd_en_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/cvvt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvvt_back: event sequencer
// Walks the head batch one event per cycle, unless a result is held unpopped, into the result register.
// ----------------------------------------------------------------------------
module cvvt_back import cvvt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     batch_valid_i,
  input  batch_t   batch_i,
  output logic     batch_pop_o,
  output logic     empty_o,
  input  logic     pop_i,
  output out_res_t res_o
);

  logic              out_valid_q;
  out_res_t          out_q, out_d;
  logic [EvIdxW-1:0] idx_q;
  logic              load;
  logic              is_final;
  evt_t              cur;

  assign cur      = batch_i.evts[idx_q];
  assign is_final = (idx_q == batch_i.last_idx);
  // result slot is free now or frees at this edge
  assign load     = batch_valid_i && (!out_valid_q || pop_i);

  assign batch_pop_o = load && is_final;
  assign empty_o     = !out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    out_d.token_kind  = cur.kind;
    out_d.event_res   = cur.ev;
    out_d.data_byte   = cur.data;
    out_d.last_of_run = is_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_final ? '0 : idx_q + EvIdxW'(1);
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

[rtl/const_value_vector_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// const_value_vector_tokenizer: streaming const/value/vector token scanner
// Classifier, batch queue and event sequencer; one text byte per request.
// ----------------------------------------------------------------------------
// Flow: the events of a byte are written as a batch into the batch queue, then
//   moved into the result register one per cycle unless a result is held unpopped.
// Throughput: one byte per cycle while full is low, one event per cycle out unless
//   a result is held; full rises only when all QueueDepth queue entries hold batches.
// Reset: asynchronous, clears the scan mode to top level and empties the queue
//   and the result register.
module const_value_vector_tokenizer import cvvt_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  in_req_t  in_req_i,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output out_res_t out_res_o
);

  logic   q_full;
  logic   ready;
  logic   wr_en;
  batch_t wr_batch;
  logic   rd_en;
  logic   rd_valid;
  batch_t rd_batch;

  assign full = !ready;

  cvvt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (push),
    .req_i         (in_req_i),
    .q_full_i      (q_full),
    .req_ready_o   (ready),
    .batch_valid_o (wr_en),
    .batch_o       (wr_batch)
  );

  cvvt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_batch),
    .full_o    (q_full),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_batch),
    .valid_o   (rd_valid)
  );

  cvvt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .batch_valid_i (rd_valid),
    .batch_i       (rd_batch),
    .batch_pop_o   (rd_en),
    .empty_o       (empty),
    .pop_i         (pop),
    .res_o         (out_res_o)
  );

endmodule

[rtl/cvvt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvvt_checker: port-level checks of the token scanner
// Watches the result side over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module cvvt_checker import cvvt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input out_res_t out_res_o
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_res_o)))
    else $error("result changed while stalled");

  // events of one byte come out back to back
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_res_o.last_of_run) |=> !empty)
    else $error("gap inside an event run");

  // an unknown byte's data event is always followed by its token end
  a_unknown_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_res_o.event_res == EV_DATA &&
     out_res_o.token_kind == KIND_UNKNOWN)
    |=> (!empty && out_res_o.event_res == EV_END &&
         out_res_o.token_kind == KIND_UNKNOWN))
    else $error("unknown token not closed");

  // out of reset nothing is pending and requests are taken
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (empty && !full))
    else $error("bad state after reset");

endmodule

bind const_value_vector_tokenizer cvvt_checker u_checker (.*);
